/* design/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared sizes, payload types, result codes, datapath commands and the
// controller state type.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Table sizes and address geometry.
  localparam int FREE_SLOTS   = 64;
  localparam int LIVE_SLOTS   = 256;
  localparam int HEADER_BYTES = 24;
  localparam int ADDR_BITS    = 24;

  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
  localparam int LIDX_W = $clog2(LIVE_SLOTS);
  localparam int LCNT_W = $clog2(LIVE_SLOTS + 1);
  localparam int WIDE_W = ADDR_BITS + 2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [WIDE_W-1:0]    wide_t;

  // Request opcodes.
  localparam logic OPC_ALLOC   = 1'b0;
  localparam logic OPC_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_LIVE  = 2'd3
  } status_t;

  // One table entry: block start and length.
  typedef struct packed {
    addr_t start;
    addr_t len;
  } blk_t;

  typedef struct packed {
    logic  opcode;
    addr_t request_size;
    addr_t block_address;
  } req_t;

  typedef struct packed {
    addr_t   user_address;
    status_t status;
    addr_t   segment_size;
    addr_t   free_space;
  } res_t;

  // One datapath operation per cycle.
  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_FRD, DP_FADV, DP_SPLIT, DP_TAKE, DP_DRD, DP_DWR,
    DP_DEND, DP_GROW, DP_LWR, DP_LRD, DP_LADV, DP_LHIT, DP_MERGE2,
    DP_MERGEL, DP_MERGER, DP_ISTART, DP_IRD, DP_IWR, DP_IPUT, DP_LLAST,
    DP_LMOVE, DP_RES
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } cmd_t;

  // Status flags returned by the datapath.
  typedef struct packed {
    logic is_release;
    logic live_full;
    logic free_full;
    logic f_end;
    logic l_end;
    logic fit;
    logic split;
    logic lhit;
    logic fgt;
    logic left;
    logic right;
    logic grow_ok;
    logic drop_more;
    logic ins_more;
    logic out_free;
  } flags_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ASCAN, S_ANEXT, S_AGROW, S_ALIVE, S_DROP_CHK,
    S_DROP_WR, S_RSCAN, S_RLNEXT, S_RFNEXT, S_RFSCAN, S_RJOIN, S_ICHK,
    S_IWR, S_LLAST, S_LMOVE, S_DONE
  } state_t;

endpackage

/* design/ffha_ifs.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface ffha_req_if import ffha_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffha_res_if import ffha_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffha_cfg_if import ffha_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/ffha_dp.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Free and live tables, counters, heap top, free total, the heap limit
// register and the result register. Performs one command per cycle.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  req_t   in_data,
  input  logic   cfg_valid,
  input  addr_t  cfg_data,
  input  logic   out_ready,
  output logic   out_valid,
  output res_t   out_data,
  output flags_t flags
);

  localparam addr_t HDR_A = addr_t'(HEADER_BYTES);
  localparam wide_t HDR_W = wide_t'(HEADER_BYTES);

  blk_t free_mem [FREE_SLOTS];
  blk_t live_mem [LIVE_SLOTS];

  req_t              req_r;
  blk_t              fq_r, lq_r, prev_r;
  addr_t             start_r, got_r;
  addr_t             heap_top_r, free_total_r, limit_r;
  logic [FCNT_W-1:0] free_count_r, fidx_r, kidx_r;
  logic [LCNT_W-1:0] live_count_r, lidx_r;
  logic [LIDX_W-1:0] j_r;
  logic              out_valid_r;
  res_t              out_r;

  logic              f_we, f_re, l_we, l_re;
  logic [FIDX_W-1:0] f_waddr, f_raddr;
  logic [LIDX_W-1:0] l_waddr, l_raddr;
  blk_t              f_wdata, l_wdata;
  logic [FCNT_W-1:0] fidx_m1, fidx_p1, kidx_m1;
  logic [LCNT_W-1:0] live_m1;

  assign fidx_m1 = fidx_r - 1'b1;
  assign fidx_p1 = fidx_r + 1'b1;
  assign kidx_m1 = kidx_r - 1'b1;
  assign live_m1 = live_count_r - 1'b1;

  // Status flags for the controller.
  always_comb begin
    flags.is_release = req_r.opcode == OPC_RELEASE;
    flags.live_full  = live_count_r == LCNT_W'(LIVE_SLOTS);
    flags.free_full  = free_count_r == FCNT_W'(FREE_SLOTS);
    flags.f_end      = fidx_r == free_count_r;
    flags.l_end      = lidx_r == live_count_r;
    flags.fit        = fq_r.len >= req_r.request_size;
    flags.split      = wide_t'(fq_r.len) > wide_t'(req_r.request_size) + HDR_W;
    flags.lhit       = wide_t'(lq_r.start) + HDR_W == wide_t'(req_r.block_address);
    flags.fgt        = fq_r.start > start_r;
    flags.left       = (fidx_r != '0) &&
                       (wide_t'(prev_r.start) + wide_t'(prev_r.len) + HDR_W ==
                        wide_t'(start_r));
    flags.right      = (fidx_r < free_count_r) &&
                       (wide_t'(start_r) + wide_t'(got_r) + HDR_W ==
                        wide_t'(fq_r.start));
    flags.grow_ok    = wide_t'(heap_top_r) + wide_t'(req_r.request_size) + HDR_W <=
                       wide_t'(limit_r);
    flags.drop_more  = fidx_p1 < free_count_r;
    flags.ins_more   = kidx_r > fidx_r;
    flags.out_free   = !out_valid_r || out_ready;
  end

  // Memory port selection.
  always_comb begin
    f_we    = 1'b0;
    f_re    = 1'b0;
    l_we    = 1'b0;
    l_re    = 1'b0;
    f_waddr = fidx_r[FIDX_W-1:0];
    f_raddr = fidx_r[FIDX_W-1:0];
    l_waddr = live_count_r[LIDX_W-1:0];
    l_raddr = lidx_r[LIDX_W-1:0];
    f_wdata = fq_r;
    l_wdata = '{start: start_r, len: got_r};
    case (cmd.op)
      DP_FRD: f_re = 1'b1;
      DP_DRD: begin
        f_re    = 1'b1;
        f_raddr = fidx_p1[FIDX_W-1:0];
      end
      DP_IRD: begin
        f_re    = 1'b1;
        f_raddr = kidx_m1[FIDX_W-1:0];
      end
      DP_SPLIT: begin
        f_we    = 1'b1;
        f_wdata = '{start: fq_r.start + req_r.request_size + HDR_A,
                    len:   fq_r.len - req_r.request_size - HDR_A};
      end
      DP_DWR: f_we = 1'b1;
      DP_IWR: begin
        f_we    = 1'b1;
        f_waddr = kidx_r[FIDX_W-1:0];
      end
      DP_MERGE2: begin
        f_we    = 1'b1;
        f_waddr = fidx_m1[FIDX_W-1:0];
        f_wdata = '{start: prev_r.start,
                    len:   prev_r.len + got_r + HDR_A + fq_r.len + HDR_A};
      end
      DP_MERGEL: begin
        f_we    = 1'b1;
        f_waddr = fidx_m1[FIDX_W-1:0];
        f_wdata = '{start: prev_r.start, len: prev_r.len + got_r + HDR_A};
      end
      DP_MERGER: begin
        f_we    = 1'b1;
        f_wdata = '{start: start_r, len: fq_r.len + got_r + HDR_A};
      end
      DP_IPUT: begin
        f_we    = 1'b1;
        f_wdata = '{start: start_r, len: got_r};
      end
      DP_LWR: l_we = 1'b1;
      DP_LRD: l_re = 1'b1;
      DP_LLAST: begin
        l_re    = 1'b1;
        l_raddr = live_m1[LIDX_W-1:0];
      end
      DP_LMOVE: begin
        l_we    = 1'b1;
        l_waddr = j_r;
        l_wdata = lq_r;
      end
      default: ;
    endcase
  end

  // Table memories with registered read data.
  always_ff @(posedge clk) begin
    if (f_we) begin
      free_mem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      fq_r <= free_mem[f_raddr];
    end
    if (l_we) begin
      live_mem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      lq_r <= live_mem[l_raddr];
    end
  end

  // Control and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r <= '0;
      live_count_r <= '0;
      heap_top_r   <= '0;
      free_total_r <= '0;
      limit_r      <= '1;
      fidx_r       <= '0;
      kidx_r       <= '0;
      lidx_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      // A new result is loaded only once the previous one has been taken.
      if (cmd.op == DP_RES) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        DP_LOAD: begin
          fidx_r <= '0;
          lidx_r <= '0;
        end
        DP_FADV, DP_DWR: fidx_r <= fidx_p1;
        DP_SPLIT: free_total_r <= free_total_r - req_r.request_size - HDR_A;
        DP_TAKE:  free_total_r <= free_total_r - fq_r.len - HDR_A;
        DP_DEND:  free_count_r <= free_count_r - 1'b1;
        DP_GROW:  heap_top_r <= heap_top_r + req_r.request_size + HDR_A;
        DP_LWR:   live_count_r <= live_count_r + 1'b1;
        DP_LADV:  lidx_r <= lidx_r + 1'b1;
        DP_LHIT:  fidx_r <= '0;
        DP_MERGE2, DP_MERGEL, DP_MERGER: free_total_r <= free_total_r + got_r + HDR_A;
        DP_ISTART: kidx_r <= free_count_r;
        DP_IWR:    kidx_r <= kidx_m1;
        DP_IPUT: begin
          free_count_r <= free_count_r + 1'b1;
          free_total_r <= free_total_r + got_r + HDR_A;
        end
        DP_LLAST: live_count_r <= live_m1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: req_r <= in_data;
      DP_FADV: prev_r <= fq_r;
      DP_SPLIT: begin
        start_r <= fq_r.start;
        got_r   <= req_r.request_size;
      end
      DP_TAKE: begin
        start_r <= fq_r.start;
        got_r   <= fq_r.len;
      end
      DP_GROW: begin
        start_r <= heap_top_r;
        got_r   <= req_r.request_size;
      end
      DP_LHIT: begin
        start_r <= lq_r.start;
        got_r   <= lq_r.len;
        j_r     <= lidx_r[LIDX_W-1:0];
      end
      DP_RES: begin
        out_r.user_address <= (cmd.status == ST_OK && req_r.opcode == OPC_ALLOC) ?
                              start_r + HDR_A : '0;
        out_r.status       <= cmd.status;
        out_r.segment_size <= heap_top_r;
        out_r.free_space   <= free_total_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences the table scans, splits, merges and shifts of one request and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  // State and result code registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    cmd.op     = DP_NONE;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!flags.is_release) begin
          if (flags.live_full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (flags.f_end) begin
            state_nxt = S_AGROW;
          end else begin
            cmd.op    = DP_FRD;
            state_nxt = S_ASCAN;
          end
        end else if (flags.l_end) begin
          status_nxt = ST_NOT_LIVE;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = DP_LRD;
          state_nxt = S_RSCAN;
        end
      end
      // First-fit walk over the free table.
      S_ASCAN: begin
        if (flags.fit && flags.split) begin
          cmd.op    = DP_SPLIT;
          state_nxt = S_ALIVE;
        end else if (flags.fit) begin
          cmd.op    = DP_TAKE;
          state_nxt = S_DROP_CHK;
        end else begin
          cmd.op    = DP_FADV;
          state_nxt = S_ANEXT;
        end
      end
      S_ANEXT: begin
        if (flags.f_end) begin
          state_nxt = S_AGROW;
        end else begin
          cmd.op    = DP_FRD;
          state_nxt = S_ASCAN;
        end
      end
      S_AGROW: begin
        if (flags.grow_ok) begin
          cmd.op    = DP_GROW;
          state_nxt = S_ALIVE;
        end else begin
          status_nxt = ST_EXHAUSTED;
          state_nxt  = S_DONE;
        end
      end
      S_ALIVE: begin
        cmd.op     = DP_LWR;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end
      // Close the gap left by a removed free entry.
      S_DROP_CHK: begin
        if (flags.drop_more) begin
          cmd.op    = DP_DRD;
          state_nxt = S_DROP_WR;
        end else begin
          cmd.op    = DP_DEND;
          state_nxt = flags.is_release ? S_LLAST : S_ALIVE;
        end
      end
      S_DROP_WR: begin
        cmd.op    = DP_DWR;
        state_nxt = S_DROP_CHK;
      end
      // Search the live table for the released address.
      S_RSCAN: begin
        if (flags.lhit) begin
          cmd.op    = DP_LHIT;
          state_nxt = S_RFNEXT;
        end else begin
          cmd.op    = DP_LADV;
          state_nxt = S_RLNEXT;
        end
      end
      S_RLNEXT: begin
        if (flags.l_end) begin
          status_nxt = ST_NOT_LIVE;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = DP_LRD;
          state_nxt = S_RSCAN;
        end
      end
      // Find the insertion point in the sorted free table.
      S_RFNEXT: begin
        if (flags.f_end) begin
          state_nxt = S_RJOIN;
        end else begin
          cmd.op    = DP_FRD;
          state_nxt = S_RFSCAN;
        end
      end
      S_RFSCAN: begin
        if (flags.fgt) begin
          state_nxt = S_RJOIN;
        end else begin
          cmd.op    = DP_FADV;
          state_nxt = S_RFNEXT;
        end
      end
      S_RJOIN: begin
        if (flags.left && flags.right) begin
          cmd.op    = DP_MERGE2;
          state_nxt = S_DROP_CHK;
        end else if (flags.left) begin
          cmd.op    = DP_MERGEL;
          state_nxt = S_LLAST;
        end else if (flags.right) begin
          cmd.op    = DP_MERGER;
          state_nxt = S_LLAST;
        end else if (flags.free_full) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = DP_ISTART;
          state_nxt = S_ICHK;
        end
      end
      // Open a slot for a new free entry.
      S_ICHK: begin
        if (flags.ins_more) begin
          cmd.op    = DP_IRD;
          state_nxt = S_IWR;
        end else begin
          cmd.op    = DP_IPUT;
          state_nxt = S_LLAST;
        end
      end
      S_IWR: begin
        cmd.op    = DP_IWR;
        state_nxt = S_ICHK;
      end
      // Move the last live entry into the released slot.
      S_LLAST: begin
        cmd.op    = DP_LLAST;
        state_nxt = S_LMOVE;
      end
      S_LMOVE: begin
        cmd.op     = DP_LMOVE;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.op    = DP_RES;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* design/first_fit_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Allocates and releases heap blocks with first-fit search and coalescing.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_chan (allocate or release), one result item
// leaves on out_chan for every request. cfg_chan writes the heap limit and is
// always ready; write it only while the core is idle.
// One request is processed at a time. An allocate walks the free table one
// entry at a time, then may shift the table to close a gap, one moved entry
// at a time. A release searches the live table entry by entry, walks the
// free table to the insertion point, and may shift the free table.
// The result register frees the core for a new request as soon as the result
// is loaded; if the receiver stalls, the next result waits until it is taken.
// Reset empties both tables, clears heap top and free total, and sets the heap
// limit to its maximum; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core import ffha_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  ffha_req_if.sink   in_chan,
  ffha_res_if.source out_chan,
  ffha_cfg_if.sink   cfg_chan
);

  cmd_t   cmd;
  flags_t flags;
  logic   in_ready;
  logic   out_valid;
  res_t   out_data;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

  // Request sequencer.
  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // Tables and arithmetic.
  ffha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_chan.data),
    .cfg_valid (cfg_chan.valid),
    .cfg_data  (cfg_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .flags     (flags)
  );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the first-fit heap allocator core
// Drives allocate and release requests through several heap limits and
// handshake idling patterns. A scoreboard carries its own copy of the free
// and live tables and checks every result item field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import ffha_pkg::*;

  localparam longint unsigned FIELD_MASK = 64'hFF_FFFF;
  localparam longint unsigned HDR        = HEADER_BYTES;
  localparam int              CYCLE_CAP  = 6000000;

  // Heap bookkeeping plus the queue of results still owed by the core.
  class heap_scoreboard;
    longint unsigned limit;
    longint unsigned fr_start[FREE_SLOTS];
    longint unsigned fr_len[FREE_SLOTS];
    int              fr_cnt;
    longint unsigned lv_start[LIVE_SLOTS];
    longint unsigned lv_len[LIVE_SLOTS];
    int              lv_cnt;
    longint unsigned top;
    longint unsigned free_sum;
    res_t            owed[$];
    int              errors;

    function new();
      limit    = FIELD_MASK;
      fr_cnt   = 0;
      lv_cnt   = 0;
      top      = 0;
      free_sum = 0;
      errors   = 0;
    endfunction

    function void drop_free(int idx);
      for (int k = idx; k + 1 < fr_cnt; k++) begin
        fr_start[k] = fr_start[k+1];
        fr_len[k]   = fr_len[k+1];
      end
      fr_cnt--;
    endfunction

    // First fit, split when the block has room for another header.
    function status_t grant(longint unsigned size, output longint unsigned user);
      longint unsigned start, got;
      int i;
      user = 0;
      if (lv_cnt >= LIVE_SLOTS) return ST_FULL;
      for (i = 0; i < fr_cnt; i++)
        if (fr_len[i] >= size) break;
      if (i < fr_cnt) begin
        start = fr_start[i];
        if (fr_len[i] > size + HDR) begin
          fr_start[i] = (start + size + HDR) & FIELD_MASK;
          fr_len[i]   = fr_len[i] - size - HDR;
          got = size;
        end else begin
          got = fr_len[i];
          drop_free(i);
        end
        free_sum -= got + HDR;
      end else begin
        if (top + size + HDR > limit) return ST_EXHAUSTED;
        start = top;
        top += size + HDR;
        got = size;
      end
      lv_start[lv_cnt] = start;
      lv_len[lv_cnt]   = got;
      lv_cnt++;
      user = (start + HDR) & FIELD_MASK;
      return ST_OK;
    endfunction

    // Return a live block to the sorted free table, joining neighbors.
    function status_t give_back(longint unsigned addr);
      longint unsigned s, l;
      int j, p;
      bit left, right;
      for (j = 0; j < lv_cnt; j++)
        if (lv_start[j] + HDR == addr) break;
      if (j == lv_cnt) return ST_NOT_LIVE;
      s = lv_start[j];
      l = lv_len[j];
      for (p = 0; p < fr_cnt; p++)
        if (fr_start[p] > s) break;
      left  = p > 0 && fr_start[p-1] + fr_len[p-1] + HDR == s;
      right = p < fr_cnt && s + l + HDR == fr_start[p];
      if (left && right) begin
        fr_len[p-1] += l + HDR + fr_len[p] + HDR;
        drop_free(p);
      end else if (left) begin
        fr_len[p-1] += l + HDR;
      end else if (right) begin
        fr_start[p] = s;
        fr_len[p]  += l + HDR;
      end else begin
        if (fr_cnt >= FREE_SLOTS) return ST_FULL;
        for (int k = fr_cnt; k > p; k--) begin
          fr_start[k] = fr_start[k-1];
          fr_len[k]   = fr_len[k-1];
        end
        fr_start[p] = s;
        fr_len[p]   = l;
        fr_cnt++;
      end
      free_sum += l + HDR;
      lv_cnt--;
      lv_start[j] = lv_start[lv_cnt];
      lv_len[j]   = lv_len[lv_cnt];
      return ST_OK;
    endfunction

    // An accepted request: work out the result it must produce.
    function void note_request(req_t r);
      res_t e;
      longint unsigned user;
      if (r.opcode == OPC_ALLOC) e.status = grant(r.request_size, user);
      else e.status = give_back(r.block_address);
      if (e.status != ST_OK || r.opcode == OPC_RELEASE) user = 0;
      e.user_address = user & FIELD_MASK;
      e.segment_size = top & FIELD_MASK;
      e.free_space   = free_sum & FIELD_MASK;
      owed.push_back(e);
    endfunction

    // An accepted result item: compare with the oldest expectation.
    function void check_result(res_t a);
      res_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", a);
        return;
      end
      e = owed.pop_front();
      if (a.user_address !== e.user_address || a.status !== e.status ||
          a.segment_size !== e.segment_size || a.free_space !== e.free_space) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected addr %h st %0d seg %h free %h, got addr %h st %0d seg %h free %h",
                   e.user_address, e.status, e.segment_size, e.free_space,
                   a.user_address, a.status, a.segment_size, a.free_space);
      end
    endfunction

    // A user address picked from the live blocks, or any address if none.
    function addr_t live_pick();
      if (lv_cnt == 0) return addr_t'($urandom);
      return addr_t'(lv_start[$urandom_range(lv_cnt - 1)] + HDR);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ffha_req_if in_if();
  ffha_res_if out_if();
  ffha_cfg_if cfg_if();

  first_fit_heap_allocator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source),
    .cfg_chan (cfg_if.sink)
  );

  heap_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_request;
  int  hold_left;
  int  cycles;

  always #10 clk = ~clk;

  initial begin
    clk            = 0;
    rst_n          = 0;
    in_if.valid    = 0;
    in_if.data     = '0;
    out_if.ready   = 0;
    cfg_if.valid   = 0;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    cycles         = 0;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watch both channels; requests are noted before results are checked.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_request(in_if.data);
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  task automatic send_req(logic op, addr_t size, addr_t addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid              <= 1'b1;
    in_if.data.opcode        <= op;
    in_if.data.request_size  <= size;
    in_if.data.block_address <= addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Let every owed result come back, then a few quiet cycles.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(addr_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.limit = v;
  endtask

  // Mostly small sizes; now and then large or fully random.
  function automatic addr_t pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return addr_t'($urandom_range(64));
    if (r < 95) return addr_t'($urandom_range(4000));
    return addr_t'($urandom);
  endfunction

  // Mixes: allocate share in percent; release mostly targets live blocks.
  task automatic run_phase(addr_t lim, int idle, int stall, int n, int alloc_pct);
    write_limit(lim);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < alloc_pct)
        send_req(OPC_ALLOC, pick_size(), addr_t'($urandom));
      else if ($urandom_range(9) != 0)
        send_req(OPC_RELEASE, addr_t'($urandom), sb.live_pick());
      else
        send_req(OPC_RELEASE, addr_t'($urandom), addr_t'($urandom));
    end
    drain();
  endtask

  initial begin
    addr_t a;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, exhaustion, split, whole take, joins, bad releases.
    send_req(OPC_ALLOC, 24'd0, 24'd0);
    send_req(OPC_ALLOC, 24'hFF_FFFF, 24'hFF_FFFF);
    send_req(OPC_ALLOC, 24'd100, 24'd0);
    send_req(OPC_ALLOC, 24'd40, 24'd0);
    send_req(OPC_ALLOC, 24'd10, 24'd0);
    send_req(OPC_RELEASE, 24'd0, 24'd48);
    send_req(OPC_RELEASE, 24'd0, 24'd48);
    send_req(OPC_RELEASE, 24'hFF_FFFF, 24'hFF_FFFF);
    send_req(OPC_RELEASE, 24'd0, 24'd0);
    send_req(OPC_ALLOC, 24'd20, 24'd0);
    send_req(OPC_ALLOC, 24'd50, 24'd0);
    send_req(OPC_RELEASE, 24'd0, 24'd24);
    drain();
    a = sb.live_pick();
    send_req(OPC_RELEASE, 24'd0, a);
    drain();
    while (sb.lv_cnt != 0) begin
      a = sb.live_pick();
      send_req(OPC_RELEASE, 24'd0, a);
      drain();
    end
    send_req(OPC_ALLOC, 24'd1000, 24'd0);
    send_req(OPC_ALLOC, 24'h80_0000, 24'h55_AAAA);
    drain();

    // Zero limit and a limit of exactly one header.
    write_limit(24'd0);
    send_req(OPC_ALLOC, 24'd5000, 24'd0);
    send_req(OPC_ALLOC, 24'd0, 24'd0);
    drain();
    write_limit(24'd24);
    send_req(OPC_ALLOC, 24'd0, 24'd0);
    drain();

    run_phase(24'hFF_FFFF, 0, 0, 300, 55);
    run_phase(24'd4000, 69, 0, 250, 55);
    run_phase(24'hFF_FFFF, 0, 69, 300, 90);   // fills the live table
    run_phase(24'hFF_FFFF, 29, 29, 250, 25);  // fragments the free table
    run_phase(24'd0, 0, 0, 150, 55);

    // Long receiver hold-off while requests keep coming.
    hold_request = 1;
    run_phase(24'hFF_FFFF, 0, 0, 300, 55);
    run_phase(24'd123456, 29, 29, 150, 55);

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/ffha_pkg.sv
design/ffha_ifs.sv
design/ffha_dp.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator_core.sv
bench/tb.sv
